[sv/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, constants and the microcode table of the segment duplicate
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // Fixed field widths of the register and the result.
  localparam int unsigned THR_W       = 14;
  localparam int unsigned CNT_OUT_W   = 9;
  localparam logic [THR_W-1:0] THR_RESET = 14'd50;

  // Microcode step address.
  typedef logic [1:0] step_t;

  // Jump conditions. A true condition loads the target, otherwise the
  // step counter advances by one.
  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_NO_INPUT  = 2'd1,
    COND_SCAN_BUSY = 2'd2,
    COND_OUT_BUSY  = 2'd3
  } cond_t;

  // One control word of the program.
  typedef struct packed {
    logic  take;
    logic  scan;
    logic  commit;
    cond_t cond;
    step_t target;
  } cword_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } sdf_ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic scan_busy;
    logic out_busy;
  } sdf_stat_t;

  // Program steps.
  localparam step_t STEP_WAIT   = 2'd0;
  localparam step_t STEP_SCAN   = 2'd1;
  localparam step_t STEP_HOLD   = 2'd2;
  localparam step_t STEP_COMMIT = 2'd3;

  // Microcode table: wait for a request, scan the table, wait for the
  // result register to free up, then commit and go back to waiting.
  function automatic cword_t sdf_rom(input step_t step);
    cword_t cw;
    cw = '0;
    unique case (step)
      STEP_WAIT: begin
        cw.take   = 1'b1;
        cw.cond   = COND_NO_INPUT;
        cw.target = STEP_WAIT;
      end
      STEP_SCAN: begin
        cw.scan   = 1'b1;
        cw.cond   = COND_SCAN_BUSY;
        cw.target = STEP_SCAN;
      end
      STEP_HOLD: begin
        cw.cond   = COND_OUT_BUSY;
        cw.target = STEP_HOLD;
      end
      STEP_COMMIT: begin
        cw.commit = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_WAIT;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[sv/segment_duplicate_filter_core.sv]
// ----------------------------------------------------------------------------
// segment_duplicate_filter_core
// Rejects line segments that lie close to a segment already kept in the
// table for the current frame, and appends the others while it has room.
//
//   Channel  Direction  Handshake            Content
//   in_*     input      in_valid / in_stall  frame_start and two endpoints
//   out_*    output     out_valid/out_stall  accepted, overflow, stored_count
//   cfg_*    input      cfg_valid/cfg_ready  dup_threshold
//
// A kept item is compared against every entry in the table; a match
// ends the table scan early. The scan reads one table entry per cycle
// from the single read port of the segment memory, with two compare
// stages behind it.
// Reset clears the entry count, the threshold to 50 and all control state.
// The result register lets the next request enter while a result waits;
// a second result waits in the sequencer until out_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_duplicate_filter_core #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned COORD_BITS   = 12
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_frame_start,
  input  wire [COORD_BITS-1:0]           in_start_x,
  input  wire [COORD_BITS-1:0]           in_start_y,
  input  wire [COORD_BITS-1:0]           in_end_x,
  input  wire [COORD_BITS-1:0]           in_end_y,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_accepted,
  output logic                           out_overflow,
  output logic [sdf_pkg::CNT_OUT_W-1:0]  out_stored_count,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [sdf_pkg::THR_W-1:0]       cfg_dup_threshold
);
  import sdf_pkg::*;

  sdf_ctl_t         ctl;
  sdf_stat_t        stat;
  logic [THR_W-1:0] thr_r;

  // Threshold register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_dup_threshold;
    end
  end

  // Microcode sequencer.
  sdf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Table, compare and result datapath.
  sdf_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .thr              (thr_r),
    .in_frame_start   (in_frame_start),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_overflow     (out_overflow),
    .out_stored_count (out_stored_count)
  );

  // A commit never overwrites a result that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !(out_valid && out_stall))
    else $error("commit while result register is occupied");

  // One request at a time: the cycle after an accept the input stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken before the first finished");

  // Overflow is only reported for kept segments.
  a_ovf_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_accepted)
    else $error("overflow on a rejected segment");

endmodule

`default_nettype wire

[sv/sdf_seq.sv]
// ----------------------------------------------------------------------------
// sdf_seq
// Microcode sequencer: step counter, control table lookup and conditional
// jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  sdf_pkg::sdf_stat_t stat,
  output sdf_pkg::sdf_ctl_t  ctl
);
  import sdf_pkg::*;

  step_t  upc_r;
  step_t  upc_nxt;
  cword_t cw;
  logic   jump;

  // Fetch the control word of the current step.
  assign cw = sdf_rom(upc_r);

  // Evaluate the jump condition.
  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !in_valid;
      COND_SCAN_BUSY: jump = stat.scan_busy;
      COND_OUT_BUSY:  jump = stat.out_busy;
      default:        jump = 1'b1;
    endcase
    upc_nxt = jump ? cw.target : step_t'(upc_r + 1'b1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Strobes to the datapath and the input handshake.
  assign in_stall   = !cw.take;
  assign ctl.load   = cw.take && in_valid;
  assign ctl.scan   = cw.scan;
  assign ctl.commit = cw.commit;

endmodule

`default_nettype wire

[sv/sdf_datapath.sv]
// ----------------------------------------------------------------------------
// sdf_datapath
// Segment table memory, pipelined distance compare, entry count and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_datapath #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned COORD_BITS   = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  sdf_pkg::sdf_ctl_t                ctl,
  output sdf_pkg::sdf_stat_t               stat,
  input  wire [sdf_pkg::THR_W-1:0]         thr,
  input  wire                              in_frame_start,
  input  wire [COORD_BITS-1:0]             in_start_x,
  input  wire [COORD_BITS-1:0]             in_start_y,
  input  wire [COORD_BITS-1:0]             in_end_x,
  input  wire [COORD_BITS-1:0]             in_end_y,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_accepted,
  output logic                             out_overflow,
  output logic [sdf_pkg::CNT_OUT_W-1:0]    out_stored_count
);
  import sdf_pkg::*;

  localparam int unsigned AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EW    = 4 * COORD_BITS;
  localparam int unsigned SUM_W = COORD_BITS + 2;
  localparam int unsigned CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  typedef logic [COORD_BITS-1:0] coord_t;

  logic [EW-1:0]    mem [MAX_SEGMENTS];
  logic [EW-1:0]    item_r;
  logic [EW-1:0]    rd_data_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic             v1_r;
  logic             v2_r;
  logic             dup_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             out_valid_r;
  logic             out_accepted_r;
  logic             out_overflow_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic             issue;
  logic             hit;
  logic             full;
  logic             store;
  logic [CW-1:0]    cnt_after;
  logic [CW+CNT_OUT_W-1:0] cnt_wide;

  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // Issue one table read per scan cycle while entries remain and no match.
  assign issue = ctl.scan && !dup_r && (idx_r < cnt_r);

  // Sum of absolute coordinate differences against the entry just read.
  always_comb begin
    sum_nxt = SUM_W'(absdiff(item_r[0*COORD_BITS +: COORD_BITS],
                             rd_data_r[0*COORD_BITS +: COORD_BITS]))
            + SUM_W'(absdiff(item_r[1*COORD_BITS +: COORD_BITS],
                             rd_data_r[1*COORD_BITS +: COORD_BITS]))
            + SUM_W'(absdiff(item_r[2*COORD_BITS +: COORD_BITS],
                             rd_data_r[2*COORD_BITS +: COORD_BITS]))
            + SUM_W'(absdiff(item_r[3*COORD_BITS +: COORD_BITS],
                             rd_data_r[3*COORD_BITS +: COORD_BITS]));
  end

  // Compare the registered sum against the threshold.
  assign hit = CMP_W'(sum_r) < CMP_W'(thr);

  // Commit decision.
  assign full      = (cnt_r == CW'(MAX_SEGMENTS));
  assign store     = !dup_r && !full;
  assign cnt_after = store ? CW'(cnt_r + 1'b1) : cnt_r;
  assign cnt_wide  = {{CNT_OUT_W{1'b0}}, cnt_after};

  // Control state: count, scan index, pipeline flags, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        if (in_frame_start) begin
          cnt_r <= '0;
        end
        idx_r <= '0;
        v1_r  <= 1'b0;
        v2_r  <= 1'b0;
        dup_r <= 1'b0;
      end else if (ctl.scan) begin
        v1_r <= issue;
        v2_r <= v1_r;
        if (issue) begin
          idx_r <= CW'(idx_r + 1'b1);
        end
        if (v2_r && hit) begin
          dup_r <= 1'b1;
        end
      end else if (ctl.commit) begin
        cnt_r <= cnt_after;
      end

      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= {in_end_y, in_end_x, in_start_y, in_start_x};
    end
    sum_r <= sum_nxt;
    if (ctl.commit) begin
      out_accepted_r <= !dup_r;
      out_overflow_r <= !dup_r && full;
      out_count_r    <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  // Segment table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.commit && store) begin
      mem[cnt_r[AW-1:0]] <= item_r;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  // Status to the sequencer.
  assign stat.scan_busy = !dup_r && ((idx_r != cnt_r) || v1_r || v2_r);
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_overflow     = out_overflow_r;
  assign out_stored_count = out_count_r;

endmodule

`default_nettype wire
